// ===== hdl/gbe_pkg.sv =====
// shared types and codes for the gap buffer editor
`default_nettype none
package gbe_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned CharW   = 8;
  localparam int unsigned ColW    = 9;
  localparam int unsigned StatusW = 2;

  localparam logic [ModeW-1:0] MODE_INSERT = 3'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 3'd1;
  localparam logic [ModeW-1:0] MODE_FWD    = 3'd2;
  localparam logic [ModeW-1:0] MODE_BACK   = 3'd3;
  localparam logic [ModeW-1:0] MODE_MOVE   = 3'd4;

  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_BOUND = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CharW-1:0] char_in;
    logic [ColW-1:0]  target;
  } cmd_word_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ColW-1:0]    cursor;
    logic [ColW-1:0]    tail_len;
    logic [CharW-1:0]   next_char;
    logic               next_valid;
  } res_word_t;

endpackage
`default_nettype wire

// ===== hdl/gbe_store.sv =====
// byte store of the gap buffer: one write port, one registered read port
`default_nettype none
module gbe_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gap_buffer_editor_unit.sv =====
// gap buffer editor for one text line: sequencer around a byte store
//
// Command channel (cmd_valid / cmd_stall / cmd_word) carries one edit per word:
// insert, delete before cursor, step forward, step back, move to column.
// Result channel (res_valid / res_stall / res_word) returns exactly one word
// per command with status, cursor, tail length and the byte after the cursor.
// Sequence: insert, delete, unused modes and refused steps go from idle
// straight to the peek read and peek wait states. Every byte copied across
// the gap takes a store read, then a store write, so a step or a move passes
// through the copy read and copy write states once per byte before the peek.
// The result is loaded in the peek wait state, and the sequencer returns to
// idle as it loads it. A new command is taken once the sequencer is back in
// idle, even while a result still waits in the output register. If the
// receiver stalls and the output register is still full, the sequencer holds
// its finished result until the register frees up.
// Reset (rst, synchronous) empties the line: cursor and tail length go to 0;
// the store contents are not cleared and need not be.
`default_nettype none
module gap_buffer_editor_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire gbe_pkg::cmd_word_t cmd_word,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output gbe_pkg::res_word_t      res_word
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > gbe_pkg::ColW) ? CW : gbe_pkg::ColW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_PEEK_RD,
    S_PEEK_WAIT
  } state_t;

  state_t state;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [CW-1:0] goal;
  logic          back;
  logic [gbe_pkg::StatusW-1:0] status;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          cmd_take;
  logic          full;
  logic [CW-1:0] len;
  logic [CW-1:0] clamp;
  logic          over;
  logic [CW-1:0] tail_start;
  logic [CW-1:0] head_m1;
  logic [CW-1:0] tail_start_m1;
  logic [XW-1:0] head_x;
  logic [XW-1:0] tail_x;
  logic          res_free;

  assign cmd_stall     = (state != S_IDLE);
  assign cmd_take      = cmd_valid && (state == S_IDLE);
  assign full          = ({1'b0, head} + {1'b0, tail}) >= {1'b0, CapC};
  assign len           = head + tail;
  assign over          = XW'(cmd_word.target) > XW'(len);
  assign clamp         = over ? len : CW'(cmd_word.target);
  assign tail_start    = CapC - tail;
  assign head_m1       = head - CW'(1);
  assign tail_start_m1 = tail_start - CW'(1);
  assign head_x        = XW'(head);
  assign tail_x        = XW'(tail);
  assign res_free      = !res_valid || !res_stall;

  gbe_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head[AW-1:0];
    mem_wdata = cmd_word.char_in;
    mem_re    = 1'b0;
    mem_raddr = tail_start[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (cmd_take && cmd_word.mode == gbe_pkg::MODE_INSERT && !full) begin
          mem_we = 1'b1;
        end
      end
      S_COPY_RD: begin
        if (head > goal) begin
          mem_re    = 1'b1;
          mem_raddr = head_m1[AW-1:0];
        end else if (head < goal) begin
          mem_re = 1'b1;
        end
      end
      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        mem_waddr = back ? tail_start_m1[AW-1:0] : head[AW-1:0];
      end
      S_PEEK_RD: begin
        mem_re = (tail != '0);
      end
      S_PEEK_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_PEEK_WAIT && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            unique case (cmd_word.mode)
              gbe_pkg::MODE_INSERT: begin
                if (full) begin
                  status <= gbe_pkg::ST_FULL;
                end else begin
                  status <= gbe_pkg::ST_DONE;
                  head   <= head + CW'(1);
                end
                state <= S_PEEK_RD;
              end
              gbe_pkg::MODE_DELETE: begin
                if (head != '0) begin
                  status <= gbe_pkg::ST_DONE;
                  head   <= head_m1;
                end else begin
                  status <= gbe_pkg::ST_BOUND;
                end
                state <= S_PEEK_RD;
              end
              gbe_pkg::MODE_FWD: begin
                if (tail == '0) begin
                  status <= gbe_pkg::ST_BOUND;
                  state  <= S_PEEK_RD;
                end else begin
                  status <= gbe_pkg::ST_DONE;
                  goal   <= head + CW'(1);
                  state  <= S_COPY_RD;
                end
              end
              gbe_pkg::MODE_BACK: begin
                if (head == '0) begin
                  status <= gbe_pkg::ST_BOUND;
                  state  <= S_PEEK_RD;
                end else begin
                  status <= gbe_pkg::ST_DONE;
                  goal   <= head_m1;
                  state  <= S_COPY_RD;
                end
              end
              gbe_pkg::MODE_MOVE: begin
                status <= over ? gbe_pkg::ST_BOUND : gbe_pkg::ST_DONE;
                goal   <= clamp;
                state  <= S_COPY_RD;
              end
              default: begin
                status <= gbe_pkg::ST_DONE;
                state  <= S_PEEK_RD;
              end
            endcase
          end
        end
        S_COPY_RD: begin
          back <= (head > goal);
          if (head == goal) begin
            state <= S_PEEK_RD;
          end else begin
            state <= S_COPY_WR;
          end
        end
        S_COPY_WR: begin
          if (back) begin
            head <= head_m1;
            tail <= tail + CW'(1);
          end else begin
            head <= head + CW'(1);
            tail <= tail - CW'(1);
          end
          state <= S_COPY_RD;
        end
        S_PEEK_RD: begin
          state <= S_PEEK_WAIT;
        end
        S_PEEK_WAIT: begin
          // hold until the output register can take the word
          if (res_free) begin
            res_word.status     <= status;
            res_word.cursor     <= head_x[gbe_pkg::ColW-1:0];
            res_word.tail_len   <= tail_x[gbe_pkg::ColW-1:0];
            res_word.next_valid <= (tail != '0);
            res_word.next_char  <= (tail != '0) ? mem_rdata : 8'd0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/gap_buffer_editor_checker.sv =====
// scoreboard for the gap buffer editor: mirrors the line, predicts and checks every result word
module gap_buffer_editor_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire logic               cmd_stall,
  input  wire gbe_pkg::cmd_word_t cmd_word,
  input  wire logic               res_valid,
  input  wire logic               res_stall,
  input  wire gbe_pkg::res_word_t res_word,
  output int                      fail_count,
  output int                      pending,
  output int                      checked,
  output int                      full_seen,
  output int                      bound_seen
);

  localparam int MAX_LINES = 50;

  logic [gbe_pkg::CharW-1:0] line_mem [CAPACITY];
  int unsigned               head_n = 0;
  int unsigned               tail_n = 0;
  gbe_pkg::res_word_t        outstanding_q [$];
  int                        n_fail = 0;
  int                        n_checked = 0;
  int                        n_full = 0;
  int                        n_bound = 0;

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= MAX_LINES) begin
      $display("%0t: result word %0d: %s", $time, n_checked, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [gbe_pkg::ColW-1:0] got,
                             input logic [gbe_pkg::ColW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    end
  endtask

  // one byte crosses the gap from the tail side into the head
  function automatic bit copy_forward();
    if (tail_n == 0) return 1'b0;
    line_mem[head_n] = line_mem[CAPACITY - tail_n];
    head_n++;
    tail_n--;
    return 1'b1;
  endfunction

  function automatic bit copy_back();
    if (head_n == 0) return 1'b0;
    line_mem[CAPACITY - tail_n - 1] = line_mem[head_n - 1];
    head_n--;
    tail_n++;
    return 1'b1;
  endfunction

  task automatic predict_edit(input gbe_pkg::cmd_word_t w, output gbe_pkg::res_word_t r);
    int unsigned                 goal;
    int unsigned                 len;
    logic [gbe_pkg::StatusW-1:0] st;
    st   = gbe_pkg::ST_DONE;
    len  = head_n + tail_n;
    goal = 32'(w.target);
    case (w.mode)
      gbe_pkg::MODE_INSERT: begin
        if (len >= CAPACITY) begin
          st = gbe_pkg::ST_FULL;
        end else begin
          line_mem[head_n] = w.char_in;
          head_n++;
        end
      end
      gbe_pkg::MODE_DELETE: begin
        if (head_n > 0) head_n--;
        else st = gbe_pkg::ST_BOUND;
      end
      gbe_pkg::MODE_FWD: begin
        if (!copy_forward()) st = gbe_pkg::ST_BOUND;
      end
      gbe_pkg::MODE_BACK: begin
        if (!copy_back()) st = gbe_pkg::ST_BOUND;
      end
      gbe_pkg::MODE_MOVE: begin
        // a column past the text clamps to the end and flags the boundary
        if (goal > len) begin
          goal = len;
          st   = gbe_pkg::ST_BOUND;
        end
        while (head_n > goal) void'(copy_back());
        while (head_n < goal) void'(copy_forward());
      end
      default: begin
      end
    endcase
    r.status   = st;
    r.cursor   = head_n[gbe_pkg::ColW-1:0];
    r.tail_len = tail_n[gbe_pkg::ColW-1:0];
    if (tail_n > 0) begin
      r.next_char  = line_mem[CAPACITY - tail_n];
      r.next_valid = 1'b1;
    end else begin
      r.next_char  = '0;
      r.next_valid = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    gbe_pkg::res_word_t want;
    if (rst) begin
      head_n = 0;
      tail_n = 0;
      outstanding_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (outstanding_q.size() == 0) begin
          report_mismatch($sformatf("arrived with no edit outstanding (%h)", res_word));
        end else begin
          want = outstanding_q.pop_front();
          check_field("status", gbe_pkg::ColW'(res_word.status),
                      gbe_pkg::ColW'(want.status));
          check_field("cursor", res_word.cursor, want.cursor);
          check_field("tail_len", res_word.tail_len, want.tail_len);
          check_field("next_char", gbe_pkg::ColW'(res_word.next_char),
                      gbe_pkg::ColW'(want.next_char));
          check_field("next_valid", gbe_pkg::ColW'(res_word.next_valid),
                      gbe_pkg::ColW'(want.next_valid));
          n_checked++;
        end
      end
      if (cmd_valid && !cmd_stall) begin
        predict_edit(cmd_word, want);
        outstanding_q.push_back(want);
        if (want.status == gbe_pkg::ST_FULL) n_full++;
        if (want.status == gbe_pkg::ST_BOUND) n_bound++;
      end
    end
    fail_count <= n_fail;
    pending    <= outstanding_q.size();
    checked    <= n_checked;
    full_seen  <= n_full;
    bound_seen <= n_bound;
  end

endmodule

// ===== sim/gap_buffer_editor_unit_tb.sv =====
// testbench top for the gap buffer editor: drives edits, stalls results, gives the verdict
module gap_buffer_editor_unit_tb;

  localparam int unsigned CAPACITY     = 256;
  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned EDIT_TARGET  = 750;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int unsigned SETTLE_TICKS = 20;

  localparam logic [gbe_pkg::ModeW-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [gbe_pkg::ModeW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [gbe_pkg::ModeW-1:0] MODE_SPARE_7 = 3'd7;

  typedef enum int {RUN_FILL, RUN_DRAIN, RUN_NAV, RUN_MIX} run_kind_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  gbe_pkg::cmd_word_t cmd_word  = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  gbe_pkg::res_word_t res_word;
  logic               calm      = 1'b0;
  int                 sent      = 0;
  int                 quiet     = 0;
  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 full_seen;
  int                 bound_seen;

  initial begin
    forever #1 clk = ~clk;
  end

  gap_buffer_editor_unit #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  gap_buffer_editor_checker #(.CAPACITY(CAPACITY)) scoreboard (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_word   (cmd_word),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .full_seen  (full_seen),
    .bound_seen (bound_seen)
  );

  always @(posedge clk) begin
    res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("no word moved on either channel for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic gbe_pkg::cmd_word_t edit(input logic [gbe_pkg::ModeW-1:0] mode,
                                              input logic [gbe_pkg::CharW-1:0] ch,
                                              input logic [gbe_pkg::ColW-1:0] col);
    gbe_pkg::cmd_word_t w;
    w.mode    = mode;
    w.char_in = ch;
    w.target  = col;
    return w;
  endfunction

  // the mix of modes depends on what the run is meant to do to the line
  function automatic gbe_pkg::cmd_word_t make_edit(input run_kind_t kind);
    gbe_pkg::cmd_word_t w;
    int unsigned        pick;
    w.char_in = gbe_pkg::CharW'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 15) w.target = gbe_pkg::ColW'($urandom_range(8));
    else if (pick < 85) w.target = gbe_pkg::ColW'($urandom_range(CAPACITY));
    else w.target = gbe_pkg::ColW'($urandom_range(511));
    pick = $urandom_range(99);
    case (kind)
      RUN_FILL: begin
        w.mode = pick < 85 ? gbe_pkg::MODE_INSERT : pick < 90 ? gbe_pkg::MODE_FWD :
                 pick < 95 ? gbe_pkg::MODE_BACK : gbe_pkg::MODE_MOVE;
      end
      RUN_DRAIN: begin
        w.mode = pick < 60 ? gbe_pkg::MODE_DELETE : pick < 75 ? gbe_pkg::MODE_BACK :
                 pick < 90 ? gbe_pkg::MODE_MOVE : gbe_pkg::MODE_INSERT;
      end
      RUN_NAV: begin
        w.mode = pick < 40 ? gbe_pkg::MODE_MOVE : pick < 65 ? gbe_pkg::MODE_FWD :
                 pick < 90 ? gbe_pkg::MODE_BACK : gbe_pkg::MODE_INSERT;
      end
      default: begin
        w.mode = gbe_pkg::ModeW'($urandom_range(7));
      end
    endcase
    return w;
  endfunction

  // valid stays high from one word to the next unless an idle cycle is drawn
  task automatic send_edit(input gbe_pkg::cmd_word_t w);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  task automatic run_edits(input run_kind_t kind, input int count);
    repeat (count) send_edit(make_edit(kind));
  endtask

  initial begin
    run_kind_t kind;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty line: every edge case that needs no text
    send_edit(edit(gbe_pkg::MODE_DELETE, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_FWD, 8'hff, 9'd0));
    send_edit(edit(gbe_pkg::MODE_BACK, 8'h00, 9'd511));
    send_edit(edit(gbe_pkg::MODE_MOVE, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_MOVE, 8'hff, 9'd511));
    send_edit(edit(MODE_SPARE_5, 8'hff, 9'd511));
    send_edit(edit(MODE_SPARE_6, 8'h3c, 9'd256));
    send_edit(edit(MODE_SPARE_7, 8'hc3, 9'd1));
    // short line, then walk the cursor around it
    send_edit(edit(gbe_pkg::MODE_INSERT, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_INSERT, 8'hff, 9'd511));
    send_edit(edit(gbe_pkg::MODE_INSERT, 8'h5a, 9'd0));
    send_edit(edit(gbe_pkg::MODE_INSERT, 8'ha5, 9'd0));
    send_edit(edit(gbe_pkg::MODE_BACK, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_BACK, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_FWD, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_MOVE, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_MOVE, 8'h00, 9'd4));
    send_edit(edit(gbe_pkg::MODE_MOVE, 8'h00, 9'd1));
    send_edit(edit(gbe_pkg::MODE_DELETE, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_MOVE, 8'h00, 9'd256));
    send_edit(edit(gbe_pkg::MODE_BACK, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_DELETE, 8'h00, 9'd0));
    send_edit(edit(gbe_pkg::MODE_FWD, 8'h00, 9'd0));

    // fill past capacity, roam the full line with no idling, then delete from it
    run_edits(RUN_FILL, 340);
    calm <= 1'b1;
    run_edits(RUN_NAV, 120);
    calm <= 1'b0;
    run_edits(RUN_DRAIN, 150);
    while (sent < EDIT_TARGET) begin
      kind = run_kind_t'($urandom_range(3));
      run_edits(kind, $urandom_range(20, 60));
    end
    cmd_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("%0d edits driven, %0d result words checked", sent, checked);
    $display("%0d inserts refused on a full line, %0d edits stopped at a boundary",
             full_seen, bound_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gbe_pkg.sv
hdl/gbe_store.sv
hdl/gap_buffer_editor_unit.sv
sim/gap_buffer_editor_checker.sv
sim/gap_buffer_editor_unit_tb.sv
